[hw/rtl/cbm_pkg.sv]
// Shared types, constants and helper functions for the clique boundary matrix builder.
// Used by cbm_ctrl and the clique_boundary_matrix_builder top level.
`default_nettype none

package cbm_pkg;

    localparam int MAX_ENTRIES = 4096;
    localparam int MAX_CLIQUE  = 5;
    localparam int VERTEX_BITS = 16;
    localparam int FACE_SLOTS  = 4;

    localparam int IN_W    = 16;
    localparam int ADDR_W  = $clog2(MAX_ENTRIES);
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int FACE_W  = FACE_SLOTS * VERTEX_BITS;
    localparam int SIZE_W  = 3;
    localparam int ROW_W   = 13;
    localparam int COL_W   = 20;
    localparam int OP_W    = 2;

    localparam logic [COL_W-1:0]  COL_MAX      = {COL_W{1'b1}};
    localparam logic [SIZE_W-1:0] SIZE_MIN     = SIZE_W'(2);
    localparam logic [SIZE_W-1:0] SIZE_MAX     = SIZE_W'(MAX_CLIQUE);
    localparam logic [SIZE_W-1:0] SIZE_RESET   = SIZE_W'(2);
    localparam logic [CNT_W-1:0]  ENTRIES_FULL = CNT_W'(MAX_ENTRIES);

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_PROBE,
        ST_CHECK,
        ST_EMIT
    } state_t;

    typedef logic [VERTEX_BITS-1:0] vertex_t;
    typedef vertex_t [MAX_CLIQUE-1:0] vset_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             found;
        logic             last;
    } res_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [FACE_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    // Clamp the written size into the supported range.
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] r;
        r = s;
        if (r < SIZE_MIN) r = SIZE_MIN;
        if (r > SIZE_MAX) r = SIZE_MAX;
        return r;
    endfunction

    // Face of n vertices with position d dropped, first vertex most significant,
    // unused low slots zero. Dropping position n-1 gives the plain n-1 prefix.
    function automatic logic [FACE_W-1:0] face_key(input vset_t v,
                                                   input logic [SIZE_W-1:0] n,
                                                   input logic [SIZE_W-1:0] d);
        logic [FACE_W-1:0] key;
        vertex_t           src;
        key = '0;
        for (int j = 0; j < FACE_SLOTS; j++) begin
            src = (SIZE_W'(j) < d) ? v[j] : v[j+1];
            if (SIZE_W'(j + 1) < n) begin
                key[FACE_W-1-j*VERTEX_BITS -: VERTEX_BITS] = src;
            end
        end
        return key;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/cbm_face_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Holds the sorted face table; no dependencies.
`default_nettype none

module cbm_face_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 64
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/cbm_ctrl.sv]
// Command sequencer: clear, append and per-face lower-bound search over the face RAM.
// Depends on cbm_pkg.
`default_nettype none

module cbm_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [cbm_pkg::SIZE_W-1:0]  cfg_data,
    input  wire logic                        item_valid,
    output logic                             item_ready,
    input  wire logic [cbm_pkg::OP_W-1:0]    operation,
    input  wire cbm_pkg::vset_t              vertices,
    output cbm_pkg::ram_req_t                ram_req,
    input  wire logic [cbm_pkg::FACE_W-1:0]  ram_rdata,
    output logic                             res_valid,
    input  wire logic                        res_ready,
    output cbm_pkg::res_t                    res
);
    import cbm_pkg::*;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  entry_count_reg, entry_count_next;
    logic [COL_W-1:0]  column_reg, column_next;
    logic [SIZE_W-1:0] size_reg, size_next;

    vset_t             vset_reg, vset_next;
    logic [SIZE_W-1:0] n_reg, n_next;
    logic [SIZE_W-1:0] d_reg, d_next;
    logic [CNT_W-1:0]  first_reg, first_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  step_reg, step_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic              found_reg, found_next;

    logic              accept;
    logic              last_face;
    logic [CNT_W-1:0]  half;
    logic [CNT_W-1:0]  probe_idx;
    logic [FACE_W-1:0] key;
    logic [SIZE_W-1:0] n_eff;

    assign accept    = item_valid && item_ready;
    assign half      = count_reg >> 1;
    assign probe_idx = first_reg + half;
    assign key       = face_key(vset_reg, n_reg, d_reg);
    assign n_eff     = eff_size(size_reg);
    assign last_face = (d_reg == n_reg - SIZE_W'(1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && operation == OP_QUERY) state_next = ST_STEP;
            end
            ST_STEP:
            begin
                if (count_reg != '0) state_next = ST_PROBE;
                else if (first_reg < entry_count_reg) state_next = ST_CHECK;
                else state_next = ST_EMIT;
            end
            ST_PROBE: state_next = ST_STEP;
            ST_CHECK: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (res_ready) state_next = last_face ? ST_IDLE : ST_STEP;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        item_ready    = (state_reg == ST_IDLE);
        res_valid     = (state_reg == ST_EMIT);
        ram_req.we    = accept && operation == OP_APPEND && entry_count_reg < ENTRIES_FULL;
        ram_req.waddr = entry_count_reg[ADDR_W-1:0];
        // append packs the first n-1 vertices: drop the last position
        ram_req.wdata = face_key(vertices, n_eff, n_eff - SIZE_W'(1));
        ram_req.re    = 1'b0;
        ram_req.raddr = probe_idx[ADDR_W-1:0];
        case (state_reg)
            ST_STEP:
            begin
                ram_req.re = 1'b1;
                if (count_reg == '0) ram_req.raddr = first_reg[ADDR_W-1:0];
            end
            default: ;
        endcase
        res.row   = ROW_W'(first_reg);
        res.col   = col_reg;
        res.found = found_reg;
        res.last  = last_face;
    end

    // Datapath
    always_comb
    begin
        entry_count_next = entry_count_reg;
        column_next      = column_reg;
        size_next        = cfg_we ? cfg_data : size_reg;
        vset_next        = vset_reg;
        n_next           = n_reg;
        d_next           = d_reg;
        first_next       = first_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        step_next        = step_reg;
        col_next         = col_reg;
        found_next       = found_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (operation)
                        OP_CLEAR:
                        begin
                            entry_count_next = '0;
                            column_next      = '0;
                        end
                        OP_APPEND:
                        begin
                            if (entry_count_reg < ENTRIES_FULL)
                                entry_count_next = entry_count_reg + CNT_W'(1);
                        end
                        OP_QUERY:
                        begin
                            vset_next  = vertices;
                            n_next     = n_eff;
                            d_next     = '0;
                            first_next = '0;
                            count_next = entry_count_reg;
                            col_next   = column_reg;
                            if (column_reg != COL_MAX) column_next = column_reg + COL_W'(1);
                        end
                        default: ;
                    endcase
                end
            end
            ST_STEP:
            begin
                idx_next   = probe_idx;
                step_next  = half;
                found_next = 1'b0;
            end
            ST_PROBE:
            begin
                if (ram_rdata < key)
                begin
                    first_next = idx_reg + CNT_W'(1);
                    count_next = count_reg - step_reg - CNT_W'(1);
                end
                else
                begin
                    count_next = step_reg;
                end
            end
            ST_CHECK: found_next = (ram_rdata == key);
            ST_EMIT:
            begin
                if (res_ready && !last_face)
                begin
                    d_next     = d_reg + SIZE_W'(1);
                    first_next = '0;
                    count_next = entry_count_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            entry_count_reg <= '0;
            column_reg      <= '0;
            size_reg        <= SIZE_RESET;
        end
        else
        begin
            state_reg       <= state_next;
            entry_count_reg <= entry_count_next;
            column_reg      <= column_next;
            size_reg        <= size_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vset_reg  <= vset_next;
        n_reg     <= n_next;
        d_reg     <= d_next;
        first_reg <= first_next;
        count_reg <= count_next;
        idx_reg   <= idx_next;
        step_reg  <= step_next;
        col_reg   <= col_next;
        found_reg <= found_next;
    end

endmodule

`default_nettype wire

[hw/rtl/clique_boundary_matrix_builder.sv]
// Clique boundary matrix builder: one (row, column) word per face of a queried clique.
// Clear and append complete in the idle state. Each face of a query runs a lower-bound
// search over the face RAM (one read port), a step and a probe state per halving, then
// a final read, a match check if the bound is in the table, and emit. Results leave through
// an output register; the emit waits until it has room. Reset clears counters, size (to 2)
// and control, not the face table. Depends on cbm_pkg, cbm_face_ram and cbm_ctrl.
`default_nettype none

module clique_boundary_matrix_builder (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [cbm_pkg::SIZE_W-1:0]  cfg_data,
    input  wire logic                        item_valid,
    output logic                             item_ready,
    input  wire logic [cbm_pkg::OP_W-1:0]    operation,
    input  wire logic [cbm_pkg::IN_W-1:0]    vertex_a,
    input  wire logic [cbm_pkg::IN_W-1:0]    vertex_b,
    input  wire logic [cbm_pkg::IN_W-1:0]    vertex_c,
    input  wire logic [cbm_pkg::IN_W-1:0]    vertex_d,
    input  wire logic [cbm_pkg::IN_W-1:0]    vertex_e,
    output logic                             result_valid,
    input  wire logic                        result_ready,
    output logic [cbm_pkg::ROW_W-1:0]        row_index,
    output logic [cbm_pkg::COL_W-1:0]        column_index,
    output logic                             face_found,
    output logic                             last_face
);
    import cbm_pkg::*;

    vset_t             vertices;
    ram_req_t          ram_req;
    logic [FACE_W-1:0] ram_rdata;
    logic              res_valid;
    logic              res_ready;
    res_t              res;

    logic out_valid_reg, out_valid_next;
    res_t out_res_reg, out_res_next;

    assign vertices[0] = vertex_a[VERTEX_BITS-1:0];
    assign vertices[1] = vertex_b[VERTEX_BITS-1:0];
    assign vertices[2] = vertex_c[VERTEX_BITS-1:0];
    assign vertices[3] = vertex_d[VERTEX_BITS-1:0];
    assign vertices[4] = vertex_e[VERTEX_BITS-1:0];

    cbm_face_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (FACE_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    cbm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .operation  (operation),
        .vertices   (vertices),
        .ram_req    (ram_req),
        .ram_rdata  (ram_rdata),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // output word register; sequencer searches on while a word waits; emit stalls
    assign res_ready = !out_valid_reg || result_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
            if (res_valid) out_res_next = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign result_valid = out_valid_reg;
    assign row_index    = out_res_reg.row;
    assign column_index = out_res_reg.col;
    assign face_found   = out_res_reg.found;
    assign last_face    = out_res_reg.last;

endmodule

`default_nettype wire
